/* hw/rtl/terminal_line_editor_assert.svh */
// Assertion macros for the line editor RTL.
// Each expects clk_i and rst_ni in the scope of the module that uses it.
`ifndef TERMINAL_LINE_EDITOR_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_ASSERT_SVH

// Checked at every clock edge outside reset.
`define TLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define TLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hw/rtl/tle_pkg.sv */
package tle_pkg;

  typedef logic [5:0] len_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_input;
  } in_t;

  typedef enum logic [2:0] {
    KIND_CONSUMED      = 3'd0,
    KIND_LINE_BYTE     = 3'd1,
    KIND_LINE_END      = 3'd2,
    KIND_END_OF_STREAM = 3'd3,
    KIND_CLEAR_SCREEN  = 3'd4,
    KIND_INTERRUPT     = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    len_t       line_length;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ESC_NORMAL = 3'd0,
    ESC_ESC    = 3'd1,
    ESC_ESCESC = 3'd2,
    ESC_SS     = 3'd3,
    ESC_CSI    = 3'd4,
    ESC_PARAM1 = 3'd5,
    ESC_PARAM2 = 3'd6
  } esc_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DECODE,
    ST_UNIT,
    ST_EMIT,
    ST_FINAL
  } state_e;

  // What a dispatched transaction needs beyond its final result.
  typedef enum logic [1:0] {
    ACT_SIMPLE,
    ACT_EMIT,
    ACT_DELETE
  } act_e;

  typedef struct packed {
    logic accept;
    logic dispatch;
    logic dec_step;
    logic unit_step;
    logic emit_step;
    logic final_load;
  } cmd_t;

  typedef struct packed {
    act_e action;
    logic unit_end;
    logic del_more;
    logic emit_last;
    logic out_free;
  } status_t;

  localparam logic [7:0] ChEtx      = 8'h03;
  localparam logic [7:0] ChFf       = 8'h0C;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChEsc      = 8'h1B;
  localparam logic [7:0] ChDel      = 8'h7F;
  localparam logic [7:0] ChLbracket = 8'h5B;
  localparam logic [7:0] ChSemi     = 8'h3B;
  localparam logic [7:0] ChUpperN   = 8'h4E;
  localparam logic [7:0] ChUpperO   = 8'h4F;
  localparam logic [7:0] ChDigit0   = 8'h30;
  localparam logic [7:0] ChDigit9   = 8'h39;
  localparam logic [7:0] ChPrintLo  = 8'h20;
  localparam logic [7:0] ChPrintHi  = 8'hF7;

  localparam logic [31:0] CpVs16   = 32'h0000_FE0F;
  localparam logic [31:0] CpZwj    = 32'h0000_200D;
  localparam logic [31:0] CpFlagLo = 32'h0001_F1E6;
  localparam logic [31:0] CpFlagHi = 32'h0001_F1FF;
  localparam logic [31:0] CpModLo  = 32'h0001_F3FB;
  localparam logic [31:0] CpModHi  = 32'h0001_F3FF;

endpackage

/* hw/rtl/terminal_line_editor.sv */
// Terminal line editor: takes one raw terminal byte per input transaction and
// returns one or more results for it, the final one flagged by last. The
// controller accepts a transaction, classifies it in the next cycle, then
// produces its results. A byte that only edits state (printable byte, escape
// byte, form feed, Ctrl-C) goes straight to its final result. CR or end of
// input outside an escape sequence first returns each held byte, as the line
// store is read one byte per cycle while the result register is free. Delete
// walks back over the stored bytes, decoding and examining one code point at
// a time. The result register frees the output side, but a transaction whose
// results meet a full result register waits for it to drain. The line store
// needs no clearing after reset; the block is ready once reset is released.
module terminal_line_editor #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tle_pkg::in_t   in_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output tle_pkg::out_t  out_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);

  tle_pkg::cmd_t    cmd;
  tle_pkg::status_t status;

  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tle_dp #(
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .status_o    (status),
    .out_o       (out_o),
    .out_valid_o (out_valid_o)
  );

endmodule

/* hw/rtl/tle_ctrl.sv */
module tle_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tle_pkg::status_t  status_i,
  output tle_pkg::cmd_t     cmd_o
);

  tle_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tle_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tle_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = tle_pkg::ST_DISPATCH;
        end
      end
      tle_pkg::ST_DISPATCH: begin
        case (status_i.action)
          tle_pkg::ACT_EMIT:   state_d = tle_pkg::ST_EMIT;
          tle_pkg::ACT_DELETE: state_d = tle_pkg::ST_DECODE;
          default:             state_d = tle_pkg::ST_FINAL;
        endcase
      end
      tle_pkg::ST_DECODE: begin
        if (status_i.unit_end) begin
          state_d = tle_pkg::ST_UNIT;
        end
      end
      tle_pkg::ST_UNIT: begin
        state_d = status_i.del_more ? tle_pkg::ST_DECODE : tle_pkg::ST_FINAL;
      end
      tle_pkg::ST_EMIT: begin
        if (status_i.out_free && status_i.emit_last) begin
          state_d = tle_pkg::ST_FINAL;
        end
      end
      tle_pkg::ST_FINAL: begin
        if (status_i.out_free) begin
          state_d = tle_pkg::ST_IDLE;
        end
      end
      default: state_d = tle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      tle_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      tle_pkg::ST_DISPATCH: cmd_o.dispatch   = 1'b1;
      tle_pkg::ST_DECODE:   cmd_o.dec_step   = 1'b1;
      tle_pkg::ST_UNIT:     cmd_o.unit_step  = 1'b1;
      tle_pkg::ST_EMIT:     cmd_o.emit_step  = status_i.out_free;
      tle_pkg::ST_FINAL:    cmd_o.final_load = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/tle_dp.sv */
`include "terminal_line_editor_assert.svh"

module tle_dp #(
  parameter int unsigned LINE_BYTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tle_pkg::in_t      in_i,
  input  tle_pkg::cmd_t     cmd_i,
  input  logic              out_ready_i,
  output tle_pkg::status_t  status_o,
  output tle_pkg::out_t     out_o,
  output logic              out_valid_o
);

  localparam int unsigned CntW = $clog2(LINE_BYTES);
  localparam logic [CntW-1:0] CountMax = CntW'(LINE_BYTES - 1);
  localparam logic [2:0] GrpSat = 3'd6;

  tle_pkg::in_t    in_q;
  tle_pkg::esc_e   esc_q, esc_d;
  logic [CntW-1:0] count_q, count_d;

  logic [7:0]      line_mem [LINE_BYTES];
  logic            mem_we;
  logic [7:0]      rd_data_q;

  logic [CntW-1:0] ptr_q, ptr_d, ptr_inc;
  logic [31:0]     acc_q, acc_d;
  logic [2:0]      grp_q, grp_d;
  logic [31:0]     dcode_q, dcode_d;
  logic [CntW-1:0] dstart_q, dstart_d;
  logic [31:0]     cur_code_q, cur_code_d;
  logic [CntW-1:0] cur_start_q, cur_start_d;
  logic            cur_valid_q, cur_valid_d;
  logic            last_pass_q, last_pass_d;
  tle_pkg::kind_e  res_kind_q, res_kind_d;
  logic            line_clear_q, line_clear_d;
  tle_pkg::out_t   out_q, out_d;
  logic            out_valid_q, out_valid_d;

  tle_pkg::act_e   cls_act;
  tle_pkg::kind_e  cls_kind;
  logic            cls_clear;
  tle_pkg::esc_e   cls_esc;
  logic [CntW-1:0] cls_count;
  logic            cls_we;

  logic            is_cont, replace, unit_end, del_more, step_a;
  logic [7:0]      bits;
  logic [31:0]     shifted, merged, dec_code;
  logic [1:0]      rule;

  function automatic tle_pkg::esc_e esc_next(input tle_pkg::esc_e s, input logic [7:0] c);
    logic          digit;
    tle_pkg::esc_e n;
    digit = c inside {[tle_pkg::ChDigit0:tle_pkg::ChDigit9]};
    n     = tle_pkg::ESC_NORMAL;
    case (s)
      tle_pkg::ESC_ESC: begin
        if (c inside {tle_pkg::ChUpperN, tle_pkg::ChUpperO}) begin
          n = tle_pkg::ESC_SS;
        end else if (c == tle_pkg::ChLbracket) begin
          n = tle_pkg::ESC_CSI;
        end else if (c == tle_pkg::ChEsc) begin
          n = tle_pkg::ESC_ESCESC;
        end
      end
      tle_pkg::ESC_ESCESC: begin
        if (c == tle_pkg::ChLbracket) begin
          n = tle_pkg::ESC_ESCESC;
        end
      end
      tle_pkg::ESC_CSI, tle_pkg::ESC_PARAM1: begin
        if (digit) begin
          n = tle_pkg::ESC_PARAM1;
        end else if (c == tle_pkg::ChSemi) begin
          n = tle_pkg::ESC_PARAM2;
        end
      end
      tle_pkg::ESC_PARAM2: begin
        if (digit) begin
          n = tle_pkg::ESC_PARAM2;
        end
      end
      default: n = tle_pkg::ESC_NORMAL;
    endcase
    return n;
  endfunction

  // {keep deleting, enter final pass}; the final pass stands for a depth of one
  function automatic logic [1:0] cluster_rule(input logic [31:0] code, input logic [31:0] prev,
                                              input logic last_pass);
    logic       code_flag;
    logic       prev_flag;
    logic       shrink;
    logic [1:0] r;
    code_flag = code inside {[tle_pkg::CpFlagLo:tle_pkg::CpFlagHi]};
    prev_flag = prev inside {[tle_pkg::CpFlagLo:tle_pkg::CpFlagHi]};
    shrink    = 1'b0;
    r         = 2'b00;
    if (code == tle_pkg::CpVs16 || code == tle_pkg::CpZwj) begin
      shrink = 1'b1;
    end else if (code_flag && prev_flag && !last_pass) begin
      r = 2'b11;
    end else if (code inside {[tle_pkg::CpModLo:tle_pkg::CpModHi]}) begin
      shrink = 1'b1;
    end else if (prev == tle_pkg::CpZwj) begin
      shrink = 1'b1;
    end
    if (shrink) begin
      r = {!last_pass, 1'b0};
    end
    return r;
  endfunction

  // Classify the held transaction
  always_comb begin
    cls_act   = tle_pkg::ACT_SIMPLE;
    cls_kind  = tle_pkg::KIND_CONSUMED;
    cls_clear = 1'b0;
    cls_esc   = esc_q;
    cls_count = count_q;
    cls_we    = 1'b0;
    if (in_q.end_of_input) begin
      cls_kind = tle_pkg::KIND_END_OF_STREAM;
      if (esc_q == tle_pkg::ESC_NORMAL) begin
        cls_clear = 1'b1;
        if (count_q != '0) begin
          cls_act = tle_pkg::ACT_EMIT;
        end
      end else begin
        // the implied CR closes any escape sequence
        cls_esc = tle_pkg::ESC_NORMAL;
      end
    end else if (in_q.rx_byte == tle_pkg::ChEtx) begin
      cls_kind = tle_pkg::KIND_INTERRUPT;
    end else if (esc_q != tle_pkg::ESC_NORMAL) begin
      cls_esc = esc_next(esc_q, in_q.rx_byte);
    end else begin
      case (in_q.rx_byte)
        tle_pkg::ChCr: begin
          cls_kind  = tle_pkg::KIND_LINE_END;
          cls_clear = 1'b1;
          if (count_q != '0) begin
            cls_act = tle_pkg::ACT_EMIT;
          end
        end
        tle_pkg::ChFf: begin
          cls_kind  = tle_pkg::KIND_CLEAR_SCREEN;
          cls_count = '0;
        end
        tle_pkg::ChEsc: cls_esc = tle_pkg::ESC_ESC;
        tle_pkg::ChDel: begin
          if (count_q != '0) begin
            cls_act = tle_pkg::ACT_DELETE;
          end
        end
        default: begin
          if (in_q.rx_byte inside {[tle_pkg::ChPrintLo:tle_pkg::ChPrintHi]} &&
              count_q < CountMax) begin
            cls_we    = 1'b1;
            cls_count = count_q + 1'b1;
          end
        end
      endcase
    end
  end

  // Backward UTF-8 decode, one stored byte per cycle
  always_comb begin
    is_cont = rd_data_q[7:6] == 2'b10;
    replace = !rd_data_q[7] || rd_data_q > tle_pkg::ChPrintHi;
    if (is_cont) begin
      bits = {2'b00, rd_data_q[5:0]};
    end else if (rd_data_q[7:5] == 3'b110) begin
      bits = {3'b000, rd_data_q[4:0]};
    end else if (rd_data_q[7:4] == 4'b1110) begin
      bits = {4'b0000, rd_data_q[3:0]};
    end else begin
      bits = {5'b00000, rd_data_q[2:0]};
    end
    // bits landing at bit 32 and above fall off
    case (grp_q)
      3'd0:    shifted = {24'd0, bits};
      3'd1:    shifted = {24'd0, bits} << 6;
      3'd2:    shifted = {24'd0, bits} << 12;
      3'd3:    shifted = {24'd0, bits} << 18;
      3'd4:    shifted = {24'd0, bits} << 24;
      3'd5:    shifted = {24'd0, bits} << 30;
      default: shifted = '0;
    endcase
    merged   = acc_q | shifted;
    dec_code = replace ? {24'd0, rd_data_q} : merged;
    unit_end = !is_cont || (ptr_q == '0);
  end

  assign ptr_inc = ptr_q + 1'b1;

  always_comb begin
    esc_d        = esc_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    acc_d        = acc_q;
    grp_d        = grp_q;
    dcode_d      = dcode_q;
    dstart_d     = dstart_q;
    cur_code_d   = cur_code_q;
    cur_start_d  = cur_start_q;
    cur_valid_d  = cur_valid_q;
    last_pass_d  = last_pass_q;
    res_kind_d   = res_kind_q;
    line_clear_d = line_clear_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    del_more     = 1'b0;
    step_a       = 1'b0;
    rule         = 2'b00;

    if (cmd_i.dispatch) begin
      esc_d        = cls_esc;
      count_d      = cls_count;
      mem_we       = cls_we;
      res_kind_d   = cls_kind;
      line_clear_d = cls_clear;
      ptr_d        = (cls_act == tle_pkg::ACT_DELETE) ? count_q - 1'b1 : '0;
      acc_d        = '0;
      grp_d        = '0;
      cur_valid_d  = 1'b0;
      last_pass_d  = 1'b0;
    end

    if (cmd_i.dec_step) begin
      if (is_cont) begin
        acc_d = merged;
        grp_d = (grp_q == GrpSat) ? grp_q : grp_q + 1'b1;
      end
      if (unit_end) begin
        dcode_d  = dec_code;
        dstart_d = ptr_q;
      end else begin
        ptr_d = ptr_q - 1'b1;
      end
    end

    // The unit just decoded is the cluster's next code point, or the one
    // before the current code point once a current one is held.
    if (cmd_i.unit_step) begin
      step_a = 1'b1;
      if (cur_valid_q) begin
        rule    = cluster_rule(cur_code_q, dcode_q, last_pass_q);
        count_d = cur_start_q;
        step_a  = rule[1];
        if (rule[0]) begin
          last_pass_d = 1'b1;
        end
      end
      if (step_a) begin
        cur_code_d  = dcode_q;
        cur_start_d = dstart_q;
        cur_valid_d = 1'b1;
        if (dstart_q == '0) begin
          count_d = '0;
        end else begin
          ptr_d    = dstart_q - 1'b1;
          acc_d    = '0;
          grp_d    = '0;
          del_more = 1'b1;
        end
      end
    end

    if (cmd_i.emit_step) begin
      out_d.kind        = tle_pkg::KIND_LINE_BYTE;
      out_d.data_byte   = rd_data_q;
      out_d.line_length = tle_pkg::len_t'(count_q);
      out_d.last        = 1'b0;
      out_valid_d       = 1'b1;
      ptr_d             = ptr_inc;
    end

    if (cmd_i.final_load) begin
      out_d.kind        = res_kind_q;
      out_d.data_byte   = '0;
      out_d.line_length = line_clear_q ? '0 : tle_pkg::len_t'(count_q);
      out_d.last        = 1'b1;
      out_valid_d       = 1'b1;
      if (line_clear_q) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q       <= tle_pkg::ESC_NORMAL;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      cur_valid_q <= 1'b0;
      last_pass_q <= 1'b0;
    end else begin
      esc_q       <= esc_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      cur_valid_q <= cur_valid_d;
      last_pass_q <= last_pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_q <= in_i;
    end
    ptr_q        <= ptr_d;
    acc_q        <= acc_d;
    grp_q        <= grp_d;
    dcode_q      <= dcode_d;
    dstart_q     <= dstart_d;
    cur_code_q   <= cur_code_d;
    cur_start_q  <= cur_start_d;
    res_kind_q   <= res_kind_d;
    line_clear_q <= line_clear_d;
    out_q        <= out_d;
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[count_q] <= in_q.rx_byte;
    end
    rd_data_q <= line_mem[ptr_d];
  end

  assign status_o.action    = cls_act;
  assign status_o.unit_end  = unit_end;
  assign status_o.del_more  = del_more;
  assign status_o.emit_last = (ptr_inc == count_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  `TLE_ASSERT(a_dec_below_count, cmd_i.dec_step |-> ptr_q < count_q, "decode pointer past line end")
  `TLE_ASSERT(a_delete_shrinks, cmd_i.unit_step |=> count_q <= $past(count_q), "delete grew the line")
  `TLE_ASSERT(a_escape_keeps_line, cmd_i.dispatch && esc_q != tle_pkg::ESC_NORMAL && !in_q.end_of_input |=> count_q == $past(count_q), "escape byte edited the line")
  `TLE_ASSERT_ALWAYS(a_byte_needs_line, out_valid_q && out_q.kind == tle_pkg::KIND_LINE_BYTE |-> count_q != '0, "line byte shown with empty line")

endmodule

/* bench/tb_top.sv */
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tle_pkg::*;

  localparam int unsigned LINE_BYTES  = 64;
  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned SCRIPT_ROWS = 26;

  typedef struct packed {
    in_t   item;
    logic  typed;
    out_t  want;
  } script_row_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  in_t   in_i        = '0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  out_t  out_o;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;

  terminal_line_editor #(
    .LINE_BYTES(LINE_BYTES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_o      (out_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Editor state mirrored by the predictor
  logic [7:0]  ed_line [LINE_BYTES];
  int unsigned ed_len = 0;
  esc_e        ed_esc = ESC_NORMAL;

  // Results of the transaction just predicted
  out_t        step_buf [LINE_BYTES + 1];
  int unsigned step_n = 0;

  out_t        expected_q [$];
  int unsigned errors = 0;
  int unsigned items_taken = 0;
  int unsigned results_seen = 0;
  int unsigned kind_count [8];

  // Driver-side notes read by the monitor at the accepting edge
  logic        typed_now = 1'b0;
  out_t        typed_want = '0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  // Receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned window_left = 0;
  int unsigned stall_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void push_result(kind_e k, logic [7:0] d);
    step_buf[step_n].kind        = k;
    step_buf[step_n].data_byte   = d;
    step_buf[step_n].line_length = len_t'(ed_len);
    step_buf[step_n].last        = 1'b0;
    step_n++;
  endfunction

  // Walks back over one UTF-8 code point ending below end_pos.
  function automatic int unsigned decode_prev_cp(input int unsigned end_pos,
                                                 output logic [31:0] cp);
    int unsigned pos;
    int unsigned shift;
    logic [7:0]  b;
    logic [31:0] acc;
    logic        done;
    pos   = end_pos;
    shift = 0;
    acc   = '0;
    done  = 1'b0;
    while (pos > 0 && !done) begin
      pos--;
      b = ed_line[pos];
      if (b[7:6] == 2'b10) begin
        // bits pushed past the top of the word are lost
        if (shift < 32) acc = acc | (32'(b[5:0]) << shift);
        shift += 6;
      end else begin
        if (b < 8'h80 || b > ChPrintHi) begin
          acc = 32'(b);
        end else if (b[7:5] == 3'b110) begin
          if (shift < 32) acc = acc | (32'(b[4:0]) << shift);
        end else if (b[7:4] == 4'b1110) begin
          if (shift < 32) acc = acc | (32'(b[3:0]) << shift);
        end else begin
          if (shift < 32) acc = acc | (32'(b[2:0]) << shift);
        end
        done = 1'b1;
      end
    end
    cp = acc;
    return pos;
  endfunction

  function automatic logic is_flag(logic [31:0] cp);
    return cp >= CpFlagLo && cp <= CpFlagHi;
  endfunction

  function automatic void remove_cluster();
    int unsigned depth;
    logic [31:0] cp;
    logic [31:0] prev_cp;
    logic        stop;
    depth = ed_len;
    stop  = 1'b0;
    while (ed_len > 0 && depth >= 1 && !stop) begin
      prev_cp = '0;
      ed_len  = decode_prev_cp(ed_len, cp);
      if (ed_len > 0) void'(decode_prev_cp(ed_len, prev_cp));
      if (cp == CpVs16 || cp == CpZwj) depth--;
      else if (is_flag(cp) && is_flag(prev_cp) && depth > 1) depth = 1;
      else if (cp >= CpModLo && cp <= CpModHi) depth--;
      else if (prev_cp == CpZwj) depth--;
      else stop = 1'b1;
    end
  endfunction

  function automatic void flush_line(kind_e marker);
    for (int unsigned i = 0; i < ed_len; i++) push_result(KIND_LINE_BYTE, ed_line[i]);
    ed_len = 0;
    push_result(marker, 8'h00);
  endfunction

  function automatic void run_filter(logic [7:0] c, kind_e cr_kind);
    logic is_digit;
    is_digit = (c >= ChDigit0 && c <= ChDigit9);
    case (ed_esc)
      ESC_NORMAL: begin
        if (c == ChCr) begin
          flush_line(cr_kind);
          return;
        end
        if (c == ChFf) begin
          ed_len = 0;
          push_result(KIND_CLEAR_SCREEN, 8'h00);
          return;
        end
        if (c == ChEsc) ed_esc = ESC_ESC;
        else if (c == ChDel) remove_cluster();
        else if (c >= ChPrintLo && c <= ChPrintHi && ed_len + 1 < LINE_BYTES) begin
          ed_line[ed_len] = c;
          ed_len++;
        end
      end
      ESC_ESC: begin
        if (c == ChUpperN || c == ChUpperO) ed_esc = ESC_SS;
        else if (c == ChLbracket) ed_esc = ESC_CSI;
        else if (c == ChEsc) ed_esc = ESC_ESCESC;
        else ed_esc = ESC_NORMAL;
      end
      ESC_ESCESC: begin
        if (c != ChLbracket) ed_esc = ESC_NORMAL;
      end
      ESC_CSI: begin
        if (is_digit) ed_esc = ESC_PARAM1;
        else if (c == ChSemi) ed_esc = ESC_PARAM2;
        else ed_esc = ESC_NORMAL;
      end
      ESC_PARAM1: begin
        if (!is_digit) ed_esc = (c == ChSemi) ? ESC_PARAM2 : ESC_NORMAL;
      end
      ESC_PARAM2: begin
        if (!is_digit) ed_esc = ESC_NORMAL;
      end
      default: ed_esc = ESC_NORMAL;
    endcase
    push_result((cr_kind == KIND_END_OF_STREAM) ? KIND_END_OF_STREAM : KIND_CONSUMED, 8'h00);
  endfunction

  function automatic void predict_edit(in_t item);
    step_n = 0;
    if (item.end_of_input) run_filter(ChCr, KIND_END_OF_STREAM);
    else if (item.rx_byte == ChEtx) push_result(KIND_INTERRUPT, 8'h00);
    else run_filter(item.rx_byte, KIND_LINE_END);
    step_buf[step_n - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void flag_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (errors < 30)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(out_t got);
    out_t want;
    if (expected_q.size() == 0) begin
      if (errors < 30)
        $display("%0t ns: result with nothing expected, expected none, got kind %0d data %0h",
                 $time, got.kind, got.data_byte);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    results_seen++;
    kind_count[want.kind]++;
    flag_field("kind",        {5'b0, want.kind},        {5'b0, got.kind});
    flag_field("data_byte",   want.data_byte,           got.data_byte);
    flag_field("line_length", {2'b0, want.line_length}, {2'b0, got.line_length});
    flag_field("last",        {7'b0, want.last},        {7'b0, got.last});
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_edit(in_i);
      items_taken++;
      if (typed_now) expected_q.push_back(typed_want);
      else for (int k = 0; k < int'(step_n); k++) expected_q.push_back(step_buf[k]);
    end
    if (rst_ni && out_valid_o && out_ready_i) check_result(out_o);
  end

  // Receiver: free-flowing, random, or long stalls, switching between these modes at random
  always @(negedge clk_i) begin
    if (window_left == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      window_left <= $urandom_range(16, 80);
    end else begin
      window_left <= window_left - 1;
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            out_ready_i <= 1'b0;
            stall_left  <= $urandom_range(1, 20);
          end else begin
            out_ready_i <= 1'b1;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_t item, logic typed, out_t want);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_i       = item;
    typed_now  = typed;
    typed_want = want;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left--;
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_t item;
    item.rx_byte      = b;
    item.end_of_input = 1'b0;
    send_item(item, 1'b0, '0);
  endtask

  task automatic send_eoi(logic [7:0] b);
    in_t item;
    item.rx_byte      = b;
    item.end_of_input = 1'b1;
    send_item(item, 1'b0, '0);
  endtask

  task automatic send_cp(logic [31:0] cp);
    if (cp < 32'h80) begin
      send_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      send_byte({3'b110, cp[10:6]});
      send_byte({2'b10, cp[5:0]});
    end else if (cp < 32'h10000) begin
      send_byte({4'b1110, cp[15:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end else begin
      send_byte({5'b11110, cp[20:18]});
      send_byte({2'b10, cp[17:12]});
      send_byte({2'b10, cp[11:6]});
      send_byte({2'b10, cp[5:0]});
    end
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_escape();
    case ($urandom_range(0, 4))
      0: begin
        send_byte(ChEsc);
        send_byte(ChLbracket);
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(ChDigit0, ChDigit9)));
        if ($urandom_range(0, 1)) begin
          send_byte(ChSemi);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(ChDigit0, ChDigit9)));
        end
        send_byte(8'($urandom_range(8'h40, 8'h7E)));
      end
      1: begin
        send_byte(ChEsc);
        send_byte($urandom_range(0, 1) ? ChUpperN : ChUpperO);
        send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      2: begin
        send_byte(ChEsc);
        send_byte(ChEsc);
        repeat ($urandom_range(0, 2)) send_byte(ChLbracket);
        send_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      3: begin
        send_byte(ChEsc);
        send_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        send_byte(ChEsc);
        send_byte(ChLbracket);
        send_byte(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic send_random_word();
    int unsigned pick;
    logic [31:0] cp;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 32) begin
      case ($urandom_range(0, 2))
        0: cp = $urandom_range(32'h80, 32'h7FF);
        1: cp = $urandom_range(32'h800, 32'hFFFF);
        default: cp = $urandom_range(32'h10000, 32'h10FFFF);
      endcase
      send_cp(cp);
    end else if (pick < 42) begin
      // emoji cluster with optional tone, selector and joined tail
      if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(8'h21, 8'h7E)));
      else send_cp($urandom_range(32'h1F600, 32'h1F64F));
      if ($urandom_range(0, 1)) send_cp($urandom_range(CpModLo, CpModHi));
      if ($urandom_range(0, 1)) send_cp(CpVs16);
      if ($urandom_range(0, 1)) begin
        send_cp(CpZwj);
        send_cp($urandom_range(32'h1F466, 32'h1F469));
      end
    end else if (pick < 48) begin
      repeat ($urandom_range(1, 3)) send_cp($urandom_range(CpFlagLo, CpFlagHi));
    end else if (pick < 62) begin
      repeat ($urandom_range(1, 3)) send_byte(ChDel);
    end else if (pick < 68) begin
      send_byte(ChCr);
    end else if (pick < 78) begin
      send_escape();
    end else if (pick < 84) begin
      case ($urandom_range(0, 3))
        0: send_byte(ChFf);
        1: send_byte(ChEtx);
        2: send_byte(8'($urandom_range(0, 31)));
        default: send_eoi(8'($urandom_range(0, 255)));
      endcase
    end else if (pick < 90) begin
      // stray continuation run, then often walk back over it
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(8'hC0, ChPrintHi)));
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(8'h80, 8'hBF)));
      if ($urandom_range(0, 2) != 0) send_byte(ChDel);
    end else if (pick < 98) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      wait_drained();
    end
  endtask

  function automatic script_row_t row(logic [7:0] b, logic eoi, logic typed, kind_e k,
                                      len_t len);
    script_row_t r;
    r.item.rx_byte      = b;
    r.item.end_of_input = eoi;
    r.typed             = typed;
    r.want.kind         = k;
    r.want.data_byte    = 8'h00;
    r.want.line_length  = len;
    r.want.last         = 1'b1;
    return r;
  endfunction

  script_row_t script [SCRIPT_ROWS];

  initial begin
    logic filled;
    filled = 1'b0;

    // Directed part; untyped rows rely on the predictor
    script[0]  = row(8'h41,      1'b0, 1'b1, KIND_CONSUMED,      6'd1);
    script[1]  = row(8'h00,      1'b0, 1'b1, KIND_CONSUMED,      6'd1);
    script[2]  = row(8'hFF,      1'b0, 1'b1, KIND_CONSUMED,      6'd1);
    script[3]  = row(ChPrintLo,  1'b0, 1'b1, KIND_CONSUMED,      6'd2);
    script[4]  = row(ChPrintHi,  1'b0, 1'b1, KIND_CONSUMED,      6'd3);
    script[5]  = row(ChEtx,      1'b0, 1'b1, KIND_INTERRUPT,     6'd3);
    script[6]  = row(ChEsc,      1'b0, 1'b1, KIND_CONSUMED,      6'd3);
    script[7]  = row(ChEtx,      1'b0, 1'b1, KIND_INTERRUPT,     6'd3);
    script[8]  = row(ChLbracket, 1'b0, 1'b1, KIND_CONSUMED,      6'd3);
    script[9]  = row(ChDigit9,   1'b0, 1'b1, KIND_CONSUMED,      6'd3);
    script[10] = row(ChSemi,     1'b0, 1'b1, KIND_CONSUMED,      6'd3);
    script[11] = row(ChDigit0,   1'b0, 1'b1, KIND_CONSUMED,      6'd3);
    script[12] = row(8'h7E,      1'b0, 1'b1, KIND_CONSUMED,      6'd3);
    script[13] = row(ChDel,      1'b0, 1'b0, KIND_CONSUMED,      6'd0);
    script[14] = row(ChCr,       1'b0, 1'b0, KIND_CONSUMED,      6'd0);
    script[15] = row(8'h7A,      1'b0, 1'b1, KIND_CONSUMED,      6'd1);
    script[16] = row(ChFf,       1'b0, 1'b1, KIND_CLEAR_SCREEN,  6'd0);
    script[17] = row(ChEsc,      1'b0, 1'b1, KIND_CONSUMED,      6'd0);
    script[18] = row(ChUpperO,   1'b0, 1'b1, KIND_CONSUMED,      6'd0);
    script[19] = row(8'hFF,      1'b1, 1'b1, KIND_END_OF_STREAM, 6'd0);
    script[20] = row(8'h78,      1'b0, 1'b1, KIND_CONSUMED,      6'd1);
    script[21] = row(8'h00,      1'b1, 1'b0, KIND_CONSUMED,      6'd0);
    script[22] = row(ChEsc,      1'b0, 1'b1, KIND_CONSUMED,      6'd0);
    script[23] = row(ChEsc,      1'b0, 1'b1, KIND_CONSUMED,      6'd0);
    script[24] = row(ChLbracket, 1'b0, 1'b1, KIND_CONSUMED,      6'd0);
    script[25] = row(ChUpperN,   1'b0, 1'b1, KIND_CONSUMED,      6'd0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < SCRIPT_ROWS; i++)
      send_item(script[i].item, script[i].typed, script[i].want);
    send_byte(ChCr);
    wait_drained();

    while (items_sent < SCRIPT_ROWS + RANDOM_ITEMS) begin
      if (!filled && items_sent > SCRIPT_ROWS + RANDOM_ITEMS / 2) begin
        // run the line into its limit, then edit and send it
        filled = 1'b1;
        repeat (58) send_byte(8'($urandom_range(8'h20, 8'h7E)));
        send_cp(CpFlagLo);
        send_cp(CpFlagHi);
        send_byte(ChDel);
        send_cp(CpFlagHi);
        send_byte(ChCr);
      end
      send_random_word();
    end
    send_byte(ChCr);

    wait_drained();
    repeat (2 * LINE_BYTES + 16) @(posedge clk_i);

    $display("Run covered %0d input transactions and %0d results checked.",
             items_taken, results_seen);
    $display("Of those: %0d lines, %0d end of stream, %0d clears, %0d interrupts.",
             kind_count[KIND_LINE_END], kind_count[KIND_END_OF_STREAM],
             kind_count[KIND_CLEAR_SCREEN], kind_count[KIND_INTERRUPT]);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results still expected", expected_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

/* terminal_line_editor.f */
+incdir+hw/rtl
hw/rtl/tle_pkg.sv
hw/rtl/tle_ctrl.sv
hw/rtl/tle_dp.sv
hw/rtl/terminal_line_editor.sv
bench/tb_top.sv
